// ----- design/eulq_pkg.sv -----
// ----------------------------------------------------------------------------
// eulq_pkg
// Shared constants and constant helpers for the roll/pitch/yaw to quaternion
// pipeline: Q.30 angle constants, CORDIC gain and arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none
package eulq_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ANGLE_WIDTH_DEF   = 16;
  localparam int TAB_STAGES        = 24;
  localparam int IO_WIDTH          = 16;
  localparam int Q_ONE             = 16384;

  localparam longint PI_Q30      = 64'sd3373259426;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint GAIN_Q30    = 64'sd652032875;

  // arctan(2^-i) in Q.30
  function automatic longint atan_q30(input int idx);
    longint v;
    case (idx)
      0:  v = 843314857;
      1:  v = 497837830;
      2:  v = 263043837;
      3:  v = 133525159;
      4:  v = 67021687;
      5:  v = 33543516;
      6:  v = 16775851;
      7:  v = 8388437;
      8:  v = 4194283;
      9:  v = 2097149;
      10: v = 1048576;
      11: v = 524288;
      12: v = 262144;
      13: v = 131072;
      14: v = 65536;
      15: v = 32768;
      16: v = 16384;
      17: v = 8192;
      18: v = 4096;
      19: v = 2048;
      20: v = 1024;
      21: v = 512;
      22: v = 256;
      23: v = 128;
      default: v = 0;
    endcase
    return v;
  endfunction

  // Round a Q.30 constant half up to frac fraction bits.
  function automatic longint from_q30(input longint c, input int frac);
    longint v;
    int     s;
    s = 30 - frac;
    if (s <= 0) begin
      v = c;
    end else begin
      v = (c + (64'sd1 <<< (s - 1))) >>> s;
    end
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- design/eulq_cordic_stage.sv -----
// ----------------------------------------------------------------------------
// eulq_cordic_stage
// One registered rotation-mode CORDIC iteration with a fixed shift.
// ----------------------------------------------------------------------------
`default_nettype none
module eulq_cordic_stage #(
  parameter int W    = 17,
  parameter int FRAC = 14,
  parameter int IDX  = 0
) (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire logic signed [W-1:0] x_in,
  input  wire logic signed [W-1:0] y_in,
  input  wire logic signed [W-1:0] h_in,
  input  wire logic                neg_in,
  output logic signed [W-1:0]      x_out,
  output logic signed [W-1:0]      y_out,
  output logic signed [W-1:0]      h_out,
  output logic                     neg_out
);

  localparam logic signed [W-1:0] ATAN_K =
    W'(eulq_pkg::from_q30(eulq_pkg::atan_q30(IDX), FRAC));

  logic signed [W-1:0] dx, dy;
  logic signed [W-1:0] x_nxt, y_nxt, h_nxt;
  logic signed [W-1:0] x_r, y_r, h_r;
  logic                neg_r;

  assign dx = y_in >>> IDX;
  assign dy = x_in >>> IDX;

  always_comb begin
    if (!h_in[W-1]) begin
      x_nxt = x_in - dx;
      y_nxt = y_in + dy;
      h_nxt = h_in - ATAN_K;
    end else begin
      x_nxt = x_in + dx;
      y_nxt = y_in - dy;
      h_nxt = h_in + ATAN_K;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      h_r   <= h_nxt;
      neg_r <= neg_in;
    end
  end

  assign x_out   = x_r;
  assign y_out   = y_r;
  assign h_out   = h_r;
  assign neg_out = neg_r;

endmodule
`default_nettype wire

// ----- design/eulq_sincos.sv -----
// ----------------------------------------------------------------------------
// eulq_sincos
// Half-angle sine and cosine: range fold, pipelined CORDIC, sign restore.
// ----------------------------------------------------------------------------
`default_nettype none
module eulq_sincos #(
  parameter int CORDIC_STAGES = eulq_pkg::CORDIC_STAGES_DEF,
  parameter int ANGLE_WIDTH   = eulq_pkg::ANGLE_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              en,
  input  wire logic signed [eulq_pkg::IO_WIDTH-1:0] angle,
  output logic signed [ANGLE_WIDTH:0]            sin_out,
  output logic signed [ANGLE_WIDTH:0]            cos_out
);

  localparam int FRAC = ANGLE_WIDTH - 2;
  localparam int W    = ANGLE_WIDTH + 1;
  localparam int STG  = (CORDIC_STAGES < eulq_pkg::TAB_STAGES) ?
                        CORDIC_STAGES : eulq_pkg::TAB_STAGES;
  localparam int EW   = (W > 17) ? W : 17;

  localparam logic signed [W-1:0] PI_F  = W'(eulq_pkg::from_q30(eulq_pkg::PI_Q30, FRAC));
  localparam logic signed [W-1:0] HP_F  =
    W'(eulq_pkg::from_q30(eulq_pkg::HALF_PI_Q30, FRAC));
  localparam logic signed [W-1:0] GAIN_F =
    W'(eulq_pkg::from_q30(eulq_pkg::GAIN_Q30, FRAC));

  logic signed [EW-1:0] r_ext;
  logic signed [W-1:0]  h0;
  logic signed [W-1:0]  h_nxt;
  logic                 neg_nxt;

  assign r_ext = EW'(angle);

  // raw Q3.13 read as Q.14 is the half angle; move it to FRAC bits
  generate
    if (FRAC >= 14) begin : g_up
      assign h0 = W'(r_ext <<< (FRAC - 14));
    end else begin : g_dn
      assign h0 = W'((r_ext + (EW'(1) <<< (13 - FRAC))) >>> (14 - FRAC));
    end
  endgenerate

  always_comb begin
    h_nxt   = h0;
    neg_nxt = 1'b0;
    if (h0 > HP_F) begin
      h_nxt   = h0 - PI_F;
      neg_nxt = 1'b1;
    end else if (h0 < -HP_F) begin
      h_nxt   = h0 + PI_F;
      neg_nxt = 1'b1;
    end
  end

  logic signed [W-1:0] x_s [STG+1];
  logic signed [W-1:0] y_s [STG+1];
  logic signed [W-1:0] h_s [STG+1];
  logic                n_s [STG+1];

  logic signed [W-1:0] h_r;
  logic                neg_r;

  always_ff @(posedge clk) begin
    if (en) begin
      h_r   <= h_nxt;
      neg_r <= neg_nxt;
    end
  end

  assign x_s[0] = GAIN_F;
  assign y_s[0] = '0;
  assign h_s[0] = h_r;
  assign n_s[0] = neg_r;

  generate
    for (genvar i = 0; i < STG; i++) begin : g_stg
      eulq_cordic_stage #(.W(W), .FRAC(FRAC), .IDX(i)) u_stage (
        .clk     (clk),
        .en      (en),
        .x_in    (x_s[i]),
        .y_in    (y_s[i]),
        .h_in    (h_s[i]),
        .neg_in  (n_s[i]),
        .x_out   (x_s[i+1]),
        .y_out   (y_s[i+1]),
        .h_out   (h_s[i+1]),
        .neg_out (n_s[i+1])
      );
    end
  endgenerate

  logic signed [W-1:0] sin_r, cos_r;

  // residual angle of the last stage is not needed
  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= (n_s[STG] && (h_s[STG] == h_s[STG])) ? -x_s[STG] : x_s[STG];
      sin_r <= n_s[STG] ? -y_s[STG] : y_s[STG];
    end
  end

  assign sin_out = sin_r;
  assign cos_out = cos_r;

endmodule
`default_nettype wire

// ----- design/eulq_combine.sv -----
// ----------------------------------------------------------------------------
// eulq_combine
// Roll/yaw cross products, pitch mixing, rounding and saturation to Q1.14.
// ----------------------------------------------------------------------------
`default_nettype none
module eulq_combine #(
  parameter int ANGLE_WIDTH = eulq_pkg::ANGLE_WIDTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic signed [ANGLE_WIDTH:0] sr,
  input  wire logic signed [ANGLE_WIDTH:0] cr,
  input  wire logic signed [ANGLE_WIDTH:0] sp,
  input  wire logic signed [ANGLE_WIDTH:0] cp,
  input  wire logic signed [ANGLE_WIDTH:0] sy,
  input  wire logic signed [ANGLE_WIDTH:0] cy,
  output logic signed [eulq_pkg::IO_WIDTH-1:0] qx,
  output logic signed [eulq_pkg::IO_WIDTH-1:0] qy,
  output logic signed [eulq_pkg::IO_WIDTH-1:0] qz,
  output logic signed [eulq_pkg::IO_WIDTH-1:0] qw
);

  localparam int FRAC = ANGLE_WIDTH - 2;
  localparam int W    = ANGLE_WIDTH + 1;
  localparam int PW   = 2 * W;
  localparam int SW   = PW + 1;
  localparam int SH   = 2 * FRAC - 14;
  localparam int OW   = eulq_pkg::IO_WIDTH;
  localparam logic signed [SW-1:0] QMAX = SW'(eulq_pkg::Q_ONE);

  // stage 1: raw roll/yaw products
  logic signed [PW-1:0] m_cc_r, m_cs_r, m_sc_r, m_ss_r;
  logic signed [W-1:0]  cp1_r, sp1_r;
  // stage 2: rounded back to FRAC
  logic signed [W-1:0]  cc_r, cs_r, sc_r, ss_r;
  logic signed [W-1:0]  cp2_r, sp2_r;
  logic signed [W-1:0]  cc_nxt, cs_nxt, sc_nxt, ss_nxt;
  // stage 3: pitch products
  logic signed [PW-1:0] px1_r, px2_r, py1_r, py2_r, pz1_r, pz2_r, pw1_r, pw2_r;
  // stage 4: sums, rounding, saturation
  logic signed [OW-1:0] qx_r, qy_r, qz_r, qw_r;

  function automatic logic signed [W-1:0] rnd_p(input logic signed [PW-1:0] v);
    logic signed [SW-1:0] t;
    t = (SW'(v) + (SW'(1) <<< (FRAC - 1))) >>> FRAC;
    return t[W-1:0];
  endfunction

  function automatic logic signed [OW-1:0] to_q14(input logic signed [SW-1:0] v);
    logic signed [SW:0]   t;
    logic signed [SW-1:0] q;
    logic signed [OW-1:0] o;
    t = ((SW+1)'(v) + ((SW+1)'(1) <<< (SH - 1))) >>> SH;
    q = t[SW-1:0];
    if (q > QMAX) begin
      o = OW'(eulq_pkg::Q_ONE);
    end else if (q < -QMAX) begin
      o = -OW'(eulq_pkg::Q_ONE);
    end else begin
      o = q[OW-1:0];
    end
    return o;
  endfunction

  assign cc_nxt = rnd_p(m_cc_r);
  assign cs_nxt = rnd_p(m_cs_r);
  assign sc_nxt = rnd_p(m_sc_r);
  assign ss_nxt = rnd_p(m_ss_r);

  always_ff @(posedge clk) begin
    if (en) begin
      m_cc_r <= cr * cy;
      m_cs_r <= cr * sy;
      m_sc_r <= sr * cy;
      m_ss_r <= sr * sy;
      cp1_r  <= cp;
      sp1_r  <= sp;

      cc_r  <= cc_nxt;
      cs_r  <= cs_nxt;
      sc_r  <= sc_nxt;
      ss_r  <= ss_nxt;
      cp2_r <= cp1_r;
      sp2_r <= sp1_r;

      px1_r <= cp2_r * sc_r;
      px2_r <= sp2_r * cs_r;
      py1_r <= cp2_r * ss_r;
      py2_r <= sp2_r * cc_r;
      pz1_r <= cp2_r * cs_r;
      pz2_r <= sp2_r * sc_r;
      pw1_r <= cp2_r * cc_r;
      pw2_r <= sp2_r * ss_r;

      qx_r <= to_q14(SW'(px1_r) - SW'(px2_r));
      qy_r <= to_q14(SW'(py1_r) + SW'(py2_r));
      qz_r <= to_q14(SW'(pz1_r) - SW'(pz2_r));
      qw_r <= to_q14(SW'(pw1_r) + SW'(pw2_r));
    end
  end

  assign qx = qx_r;
  assign qy = qy_r;
  assign qz = qz_r;
  assign qw = qw_r;

endmodule
`default_nettype wire

// ----- design/euler_rpy_to_quaternion.sv -----
// ----------------------------------------------------------------------------
// euler_rpy_to_quaternion
// Roll/pitch/yaw (Q3.13 radians) to unit quaternion (Q1.14), fully pipelined.
// ----------------------------------------------------------------------------
// Takes one beat of three angles per cycle and returns one quaternion beat
// per input beat, in order. Each angle is halved, folded into +/- pi/2, and
// run through its own CORDIC pipeline of min(CORDIC_STAGES, 24) stages; the
// roll/yaw cross products, pitch mixing and final rounding then take four
// more register stages. Throughput is one beat per cycle while the output
// side keeps stall low. A stall on the output freezes the whole pipeline and
// is passed straight back as in_stall only while a finished beat is waiting,
// so empty output slots never block new input. Results are not renormalized;
// each component is saturated to +/-1.0 (+/-16384). No state is kept between
// beats.
// ----------------------------------------------------------------------------
`default_nettype none
module euler_rpy_to_quaternion #(
  parameter int CORDIC_STAGES = eulq_pkg::CORDIC_STAGES_DEF,
  parameter int ANGLE_WIDTH   = eulq_pkg::ANGLE_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic signed [15:0] in_roll_angle,
  input  wire logic signed [15:0] in_pitch_angle,
  input  wire logic signed [15:0] in_yaw_angle,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic signed [15:0] out_quat_x,
  output logic signed [15:0] out_quat_y,
  output logic signed [15:0] out_quat_z,
  output logic signed [15:0] out_quat_w
);

  localparam int STG = (CORDIC_STAGES < eulq_pkg::TAB_STAGES) ?
                       CORDIC_STAGES : eulq_pkg::TAB_STAGES;
  // fold + CORDIC + sign restore, then three combine stages before the output
  localparam int LAT = STG + 5;

  logic                    en;
  logic [LAT-1:0]          vld_r;
  logic [LAT-1:0]          vld_nxt;
  logic                    out_valid_r;

  // advance everything when the output slot is empty or being taken
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  assign vld_nxt = {vld_r[LAT-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= vld_nxt;
      out_valid_r <= vld_r[LAT-1];
    end
  end

  logic signed [ANGLE_WIDTH:0] sr, cr, sp, cp, sy, cy;

  eulq_sincos #(.CORDIC_STAGES(CORDIC_STAGES), .ANGLE_WIDTH(ANGLE_WIDTH)) u_roll (
    .clk (clk), .en (en), .angle (in_roll_angle), .sin_out (sr), .cos_out (cr)
  );
  eulq_sincos #(.CORDIC_STAGES(CORDIC_STAGES), .ANGLE_WIDTH(ANGLE_WIDTH)) u_pitch (
    .clk (clk), .en (en), .angle (in_pitch_angle), .sin_out (sp), .cos_out (cp)
  );
  eulq_sincos #(.CORDIC_STAGES(CORDIC_STAGES), .ANGLE_WIDTH(ANGLE_WIDTH)) u_yaw (
    .clk (clk), .en (en), .angle (in_yaw_angle), .sin_out (sy), .cos_out (cy)
  );

  eulq_combine #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_combine (
    .clk (clk), .en (en),
    .sr (sr), .cr (cr), .sp (sp), .cp (cp), .sy (sy), .cy (cy),
    .qx (out_quat_x), .qy (out_quat_y), .qz (out_quat_z), .qw (out_quat_w)
  );

  assign out_valid = out_valid_r;

`ifndef NO_ASSERTIONS
  // a held result must back-pressure the input
  a_hold_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input accepted while result held");

  // an accepted beat enters the valid line
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> vld_r[0])
    else $error("accepted beat lost");

  // drop nothing from the end of the pipeline
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[LAT-1] && en |=> out_valid)
    else $error("pipeline beat lost at output");

  // x and w components stay within +/- one
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_quat_x <= 16'sd16384 && out_quat_x >= -16'sd16384 &&
                   out_quat_w <= 16'sd16384 && out_quat_w >= -16'sd16384))
    else $error("component out of range");
`endif

endmodule
`default_nettype wire
